// ===== rtl/core/cbs_pkg.sv =====
`timescale 1ns / 1ps
package cbs_pkg;

	localparam int DEGREE    = 3;
	localparam int TFRAC     = 8;
	localparam int CW        = 16;
	localparam int BW        = 28;   // basis value, common scale 3*2^26
	localparam int SW        = 46;   // weighted sum per coordinate
	localparam int SCALE_SH  = 26;
	localparam int VW        = 20;
	localparam int PW        = 39;
	localparam logic [18:0] RECIP3 = 19'd174763;  // ceil(2^19 / 3)
	localparam logic [SW-1:0] HALF_SCALE = SW'(3) << (SCALE_SH - 1);
	localparam logic [CW-1:0] SIGN_FLIP = 16'h8000;
	localparam logic [5:0] COUNT_RESET = 6'd20;
	localparam logic [5:0] COUNT_MIN = 6'd4;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} cbs_op_t;

	typedef struct packed {
		logic       write;
		logic       accept_eval;
		logic       basis_init;
		logic       basis_step;
		logic       term;
		logic [1:0] k;
		logic [1:0] r;
		logic       rd_en;
		logic       rd_end;
		logic [1:0] rd_sel;
		logic       mac_en;
		logic [1:0] mac_sel;
		logic       round_en;
		logic       mult_en;
		logic       load_out;
		logic       load_end;
	} cbs_cmd_t;

	typedef struct packed {
		logic at_end;
	} cbs_status_t;

	// clamped knot vector: four zeros, 1, 2, ..., four times n-3
	function automatic logic [5:0] knot_at(logic [6:0] i, logic [5:0] n);
		logic [5:0] res;
		if (i <= 7'(DEGREE))
			res = 6'd0;
		else if (i >= {1'b0, n})
			res = n - 6'(DEGREE);
		else
			res = 6'(i - 7'(DEGREE));
		return res;
	endfunction

	// lcm(1..k) / d for the knot gaps that can occur
	function automatic logic [2:0] ratio(logic [1:0] k, logic [5:0] d);
		logic [2:0] res;
		res = 3'd0;
		unique case (k)
			2'd1: if (d == 6'd1) res = 3'd1;
			2'd2: begin
				if (d == 6'd1) res = 3'd2;
				else if (d == 6'd2) res = 3'd1;
			end
			2'd3: begin
				if (d == 6'd1) res = 3'd6;
				else if (d == 6'd2) res = 3'd3;
				else if (d == 6'd3) res = 3'd2;
			end
			default: res = 3'd0;
		endcase
		return res;
	endfunction

endpackage

// ===== rtl/core/cbs_in_if.sv =====
`timescale 1ns / 1ps
interface cbs_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [4:0]  point_index;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic signed [15:0] coord_z;
	logic [12:0] param_t;

	modport source (output valid, op, point_index, coord_x, coord_y, coord_z, param_t,
		input ready);
	modport sink (input valid, op, point_index, coord_x, coord_y, coord_z, param_t,
		output ready);
endinterface

// ===== rtl/core/cbs_out_if.sv =====
`timescale 1ns / 1ps
interface cbs_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== rtl/core/cbs_ram.sv =====
`timescale 1ns / 1ps
module cbs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/cbs_ctrl.sv =====
`timescale 1ns / 1ps
module cbs_ctrl
	import cbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_op,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	input  cbs_status_t status,
	output cbs_cmd_t    cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_BASIS,
		S_MAC,
		S_ROUND,
		S_MULT,
		S_DONE,
		S_ENDRD,
		S_ENDLD
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;
	logic [1:0] r_q;
	logic       term_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.k    = k_q;
		cmd.r    = r_q;
		cmd.term = term_q;
		cmd.rd_sel  = cnt_q[1:0];
		cmd.mac_sel = 2'(cnt_q - 3'd1);
		unique case (state_q)
			S_IDLE: begin
				cmd.write       = in_valid && (in_op == OP_WRITE);
				cmd.accept_eval = in_valid && (in_op == OP_EVAL);
			end
			S_PREP:  cmd.basis_init = !status.at_end;
			S_BASIS: cmd.basis_step = 1'b1;
			S_MAC: begin
				cmd.rd_en  = (cnt_q != 3'd4);
				cmd.mac_en = (cnt_q != 3'd0);
			end
			S_ROUND: cmd.round_en = 1'b1;
			S_MULT:  cmd.mult_en = 1'b1;
			S_DONE:  cmd.load_out = out_free;
			S_ENDRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_end = 1'b1;
			end
			S_ENDLD: begin
				cmd.load_out = out_free;
				cmd.load_end = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 2'd1;
			r_q         <= 2'd2;
			term_q      <= 1'b0;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (cmd.accept_eval) state_q <= S_PREP;
				S_PREP: begin
					k_q    <= 2'd1;
					r_q    <= 2'd2;
					term_q <= 1'b0;
					cnt_q  <= 3'd0;
					state_q <= status.at_end ? S_ENDRD : S_BASIS;
				end
				S_BASIS: begin
					term_q <= !term_q;
					if (term_q) begin
						if (r_q == 2'd3) begin
							if (k_q == 2'd3) begin
								state_q <= S_MAC;
							end else begin
								k_q <= k_q + 2'd1;
								r_q <= 2'd2 - k_q;
							end
						end else begin
							r_q <= r_q + 2'd1;
						end
					end
				end
				S_MAC: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4)
						state_q <= S_ROUND;
				end
				S_ROUND: state_q <= S_MULT;
				S_MULT:  state_q <= S_DONE;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				S_ENDRD: state_q <= S_ENDLD;
				S_ENDLD: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/cbs_datapath.sv =====
`timescale 1ns / 1ps
module cbs_datapath
	import cbs_pkg::*;
#(
	parameter int MAX_POINTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic [4:0]  point_index,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	input  logic [12:0] param_t,
	input  cbs_cmd_t    cmd,
	output cbs_status_t status,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z
);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int NCAP = (MAX_POINTS > 63) ? 63 : MAX_POINTS;

	logic [5:0]  point_count_q;
	logic [5:0]  n_q;
	logic [5:0]  n_sat;
	logic [12:0] t_q;
	logic [BW-1:0] basis_q [4];
	logic [BW-1:0] acc_q;
	logic [SW-1:0] sum_q [3];
	logic [VW-1:0] v_q [3];
	logic [PW-1:0] prod_q [3];
	logic [15:0] res_q [3];

	// point store
	logic [8:0]  widx, ridx;
	logic        ram_we;
	logic [47:0] ram_rdata;

	assign widx   = 9'(point_index);
	assign ram_we = cmd.write && (widx < 9'(MAX_POINTS));
	assign ridx   = cmd.rd_end ? 9'(n_q - 6'd1) : 9'(t_q[12:TFRAC]) + 9'(cmd.rd_sel);

	cbs_ram #(.WIDTH(3 * CW), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx[AW-1:0]),
		.wdata ({coord_z, coord_y, coord_x}),
		.re    (cmd.rd_en),
		.raddr (ridx[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		n_sat = point_count_q;
		if (point_count_q < COUNT_MIN)
			n_sat = COUNT_MIN;
		else if (point_count_q > 6'(NCAP))
			n_sat = 6'(NCAP);
	end

	assign status.at_end = {1'b0, t_q} >= {n_q - 6'(DEGREE), 8'd0};

	// one Cox-de Boor term per cycle: left term for term 0, right term for term 1
	logic [6:0]  i_lo, i_hi;
	logic [5:0]  kn_lo, kn_hi, gap;
	logic [13:0] diff;
	logic [2:0]  rat;
	logic [12:0] coef;
	logic [BW-1:0] bsel;
	logic [BW+12:0] term_prod;
	logic [2:0]  rp1;

	assign rp1 = {1'b0, cmd.r} + 3'd1;

	always_comb begin
		i_lo = 7'(t_q[12:TFRAC]) + 7'(cmd.r) + 7'(cmd.term);
		i_hi = i_lo + 7'(cmd.k);
		kn_lo = knot_at(i_lo, n_q);
		kn_hi = knot_at(i_hi, n_q);
		gap   = kn_hi - kn_lo;
		if (!cmd.term)
			diff = {1'b0, t_q} - {kn_lo, 8'd0};
		else
			diff = {kn_hi, 8'd0} - {1'b0, t_q};
		rat = ratio(cmd.k, gap);
		unique case (rat)
			3'd1:    coef = 13'(diff);
			3'd2:    coef = 13'({diff, 1'b0});
			3'd3:    coef = 13'(diff + {diff, 1'b0});
			3'd6:    coef = 13'({diff + {diff, 1'b0}, 1'b0});
			default: coef = 13'd0;
		endcase
		if (!cmd.term)
			bsel = basis_q[cmd.r];
		else if (rp1 == 3'd4)
			bsel = '0;
		else
			bsel = basis_q[rp1[1:0]];
		term_prod = coef * bsel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			point_count_q <= COUNT_RESET;
		else if (cfg_we)
			point_count_q <= cfg_wdata;
	end

	logic [CW-1:0] pv [3];
	always_comb begin
		for (int c = 0; c < 3; c++)
			pv[c] = ram_rdata[c*CW +: CW] ^ SIGN_FLIP;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_eval) begin
			t_q <= param_t;
			n_q <= n_sat;
		end
		if (cmd.basis_init) begin
			basis_q[0] <= '0;
			basis_q[1] <= '0;
			basis_q[2] <= '0;
			basis_q[3] <= BW'(1);
			for (int c = 0; c < 3; c++)
				sum_q[c] <= '0;
		end
		if (cmd.basis_step) begin
			if (!cmd.term)
				acc_q <= BW'(term_prod);
			else
				basis_q[cmd.r] <= acc_q + BW'(term_prod);
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.mac_en)
				sum_q[c] <= sum_q[c] + SW'(basis_q[cmd.mac_sel]) * SW'(pv[c]);
			if (cmd.round_en)
				v_q[c] <= VW'((sum_q[c] + HALF_SCALE) >> SCALE_SH);
			if (cmd.mult_en)
				prod_q[c] <= PW'(v_q[c]) * PW'(RECIP3);
			if (cmd.load_out) begin
				if (cmd.load_end)
					res_q[c] <= ram_rdata[c*CW +: CW];
				else if (prod_q[c][PW-1:19] > 20'hFFFF)
					res_q[c] <= 16'hFFFF ^ SIGN_FLIP;
				else
					res_q[c] <= prod_q[c][34:19] ^ SIGN_FLIP;
			end
		end
	end

	assign out_x = res_q[0];
	assign out_y = res_q[1];
	assign out_z = res_q[2];
endmodule

// ===== rtl/core/clamped_cubic_bspline_eval_unit.sv =====
`timescale 1ns / 1ps
// Clamped uniform cubic B-spline evaluator over a store of 3-D control points.
// Channel in_ch (valid/ready) carries op, point_index, coord_x/y/z, param_t.
// op 0 writes one control point (Q4.12) and gives no result.
// op 1 evaluates the curve at param_t (Q.8) and sends one point on out_ch.
// cfg_we/cfg_wdata set point_count, the number of points in use (reset 20);
// write it only while the unit is idle.
// An evaluation runs from input transfer to output valid through prep, the
// basis recursion (two multiply steps for each of nine triangle cells on one
// shared multiplier), the weighted sum over the single store read port,
// rounding and the divide-by-three multiply.
// Parameter at or past the end of the curve: the last point is read and sent.
// One item is in work at a time; in_ch.ready is high only when idle, so no
// new item is taken while an evaluation runs, and writes go back to back.
// The result sits in an output register; a stalled receiver holds it while
// the next item is accepted, and a finished evaluation waits for it to drain.
// Reset returns the controller to idle and sets point_count to 20; the store is
// undefined until written.
module clamped_cubic_bspline_eval_unit
	import cbs_pkg::*;
#(
	parameter int MAX_POINTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	cbs_in_if.sink     in_ch,
	cbs_out_if.source  out_ch
);
	cbs_cmd_t    cmd;
	cbs_status_t status;

	cbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.status    (status),
		.cmd       (cmd)
	);

	cbs_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.point_index (in_ch.point_index),
		.coord_x     (in_ch.coord_x),
		.coord_y     (in_ch.coord_y),
		.coord_z     (in_ch.coord_z),
		.param_t     (in_ch.param_t),
		.cmd         (cmd),
		.status      (status),
		.out_x       (out_ch.out_x),
		.out_y       (out_ch.out_y),
		.out_z       (out_ch.out_z)
	);
endmodule

// ===== rtl/core/cbs_checker.sv =====
`timescale 1ns / 1ps
module cbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_op,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] out_data
);
	// output held while the receiver stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transfer dropped or changed under stall");

	// an evaluation blocks further input at once
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op |=> !in_ready)
		else $error("input accepted during evaluation");

	// a point write never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_op |=> !$rose(out_valid))
		else $error("result after a point write");

	// a result is raised only as an evaluation finishes and the unit goes idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("spurious result");
endmodule

bind clamped_cubic_bspline_eval_unit cbs_checker u_cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.op),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  ({out_ch.out_z, out_ch.out_y, out_ch.out_x})
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb
	import cbs_pkg::*;
();

	localparam int N_SLOTS = 32;
	localparam int N_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 218;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	// Curve model: point store, count register and the queue of pending curve points.
	class curve_scoreboard;
		point_t store[N_SLOTS];
		logic [5:0] count_reg;
		point_t pending[$];
		int mismatches;
		int evals;
		int checked;

		function new();
			count_reg = COUNT_RESET;
			mismatches = 0;
			evals = 0;
			checked = 0;
		endfunction

		function int knot(int i, int n);
			int res;
			if (i <= DEGREE) res = 0;
			else if (i >= n) res = n - DEGREE;
			else res = i - DEGREE;
			return res;
		endfunction

		function point_t eval_curve(logic [12:0] t_in);
			int n, span, i, d1, d2, lk;
			longint unsigned t, tmax, ui, ue, acc, scale, sum;
			longint unsigned basis[4];
			longint unsigned pv[3];
			longint unsigned q[3];
			point_t res;
			n = count_reg;
			if (n < DEGREE + 1) n = DEGREE + 1;
			if (n > N_SLOTS) n = N_SLOTS;
			t = t_in;
			tmax = longint'(n - DEGREE) << TFRAC;
			if (t >= tmax) return store[n - 1];
			span = DEGREE + int'(t >> TFRAC);
			basis = '{0, 0, 0, 1};
			scale = 1;
			for (int k = 1; k <= DEGREE; k++) begin
				lk = (k == 1) ? 1 : (k == 2) ? 2 : 6;
				for (int r = DEGREE - k; r <= DEGREE; r++) begin
					i = span - DEGREE + r;
					d1 = knot(i + k, n) - knot(i, n);
					d2 = knot(i + k + 1, n) - knot(i + 1, n);
					ui = longint'(knot(i, n)) << TFRAC;
					ue = longint'(knot(i + k + 1, n)) << TFRAC;
					acc = 0;
					if (d1 != 0 && basis[r] != 0)
						acc += (t - ui) * longint'(lk / d1) * basis[r];
					if (r < DEGREE && d2 != 0 && basis[r + 1] != 0)
						acc += (ue - t) * longint'(lk / d2) * basis[r + 1];
					basis[r] = acc;
				end
				scale = scale * (longint'(lk) << TFRAC);
			end
			for (int c = 0; c < 3; c++) begin
				sum = scale >> 1;
				for (int r = 0; r <= DEGREE; r++) begin
					i = span - DEGREE + r;
					// offset binary keeps the weighted sum unsigned
					pv[0] = longint'({16'h0, store[i].x ^ SIGN_FLIP});
					pv[1] = longint'({16'h0, store[i].y ^ SIGN_FLIP});
					pv[2] = longint'({16'h0, store[i].z ^ SIGN_FLIP});
					sum += basis[r] * pv[c];
				end
				q[c] = sum / scale;
				if (q[c] > 64'hFFFF) q[c] = 64'hFFFF;
			end
			res.x = q[0][15:0] ^ SIGN_FLIP;
			res.y = q[1][15:0] ^ SIGN_FLIP;
			res.z = q[2][15:0] ^ SIGN_FLIP;
			return res;
		endfunction

		function void note_input(cbs_op_t op, logic [4:0] idx, point_t p, logic [12:0] t);
			if (op == OP_WRITE) begin
				store[idx] = p;
			end else begin
				pending = {pending, eval_curve(t)};
				evals++;
			end
		endfunction

		function void check_result(point_t got);
			point_t exp_p;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected curve point %0d %0d %0d", got.x, got.y, got.z);
				return;
			end
			exp_p = pending.pop_front();
			checked++;
			if (got.x !== exp_p.x || got.y !== exp_p.y || got.z !== exp_p.z) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: point %0d: exp (%0d %0d %0d) got (%0d %0d %0d)", checked,
						exp_p.x, exp_p.y, exp_p.z, got.x, got.y, got.z);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	int tx_idle = 0;
	int rx_idle = 0;
	int stall_cycles = 0;
	curve_scoreboard sb = new();
	logic [5:0] counts[N_PHASES] = '{6'd4, 6'd32, 6'd20, 6'd0, 6'd63, 6'd9};
	logic [12:0] dir_t[9] = '{13'd0, 13'd1, 13'd255, 13'd256, 13'd1000,
		13'd4351, 13'd4352, 13'd4353, 13'h1FFF};

	cbs_in_if in_ch();
	cbs_out_if out_ch();

	clamped_cubic_bspline_eval_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_WRITE;
		in_ch.point_index = '0;
		in_ch.coord_x = '0;
		in_ch.coord_y = '0;
		in_ch.coord_z = '0;
		in_ch.param_t = '0;
		out_ch.ready = 1'b0;
	end

	// receive side: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_result('{out_ch.out_x, out_ch.out_y, out_ch.out_z});
			out_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send(cbs_op_t op, logic [4:0] idx, point_t p, logic [12:0] t);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.point_index <= idx;
		in_ch.coord_x <= p.x;
		in_ch.coord_y <= p.y;
		in_ch.coord_z <= p.z;
		in_ch.param_t <= t;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(op, idx, p, t);
	endtask

	task automatic settle();
		if (in_ch.valid) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.count_reg = v;
	endtask

	function automatic logic [15:0] rand_coord();
		logic [15:0] v;
		case ($urandom_range(7))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = 16'hFFFF;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [12:0] rand_param();
		int n, tmax;
		logic [12:0] t;
		n = sb.count_reg;
		if (n < 4) n = 4;
		if (n > N_SLOTS) n = N_SLOTS;
		tmax = (n - DEGREE) << TFRAC;
		case ($urandom_range(9))
			0: t = 13'(tmax);
			1: t = 13'($urandom_range(tmax + 3, tmax - 3));
			2, 3: t = 13'($urandom);
			default: t = 13'($urandom_range(tmax - 1));
		endcase
		return t;
	endfunction

	initial begin
		point_t p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot first so no evaluation reads an unwritten entry
		tx_idle = 0;
		rx_idle = 0;
		for (int s = 0; s < N_SLOTS; s++) begin
			case (s % 4)
				0: p = '{16'sh7FFF, 16'sh8000, 16'sh0000};
				1: p = '{16'sh8000, 16'sh7FFF, -16'sd1};
				default: p = '{16'($urandom), 16'($urandom), 16'($urandom)};
			endcase
			send(OP_WRITE, 5'(s), p, 13'h1FFF);
		end
		foreach (dir_t[j]) send(OP_EVAL, 5'($urandom), '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, dir_t[j]);
		settle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			tx_idle = (ph < 2) ? 12 : (ph < 4) ? 82 : 0;
			rx_idle = (ph < 2) ? 82 : (ph < 4) ? 12 : 0;
			set_count(counts[ph]);
			for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
				p = '{rand_coord(), rand_coord(), rand_coord()};
				if ($urandom_range(99) < 55)
					send(OP_WRITE, 5'($urandom), p, 13'($urandom));
				else
					send(OP_EVAL, 5'($urandom), p, rand_param());
			end
			settle();
		end

		$display("Covered %0d curve evaluations over point counts 4, 32, 20, 0, 63 and 9,",
			sb.evals);
		$display("with sender and receiver stalls in turn and back-to-back transfers.");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d points outstanding", sb.mismatches, sb.pending.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
